[sv/taf_pkg.sv]
// Shared types, codes and the quarter-wave sine table for the triangle transform.
package taf_pkg;

	typedef enum logic [2:0] {
		FN_LOAD         = 3'd0,
		FN_ROT_CENTROID = 3'd1,
		FN_ROT_ORIGIN   = 3'd2,
		FN_SCALE        = 3'd3,
		FN_TRANSLATE    = 3'd4,
		FN_SHEAR        = 3'd5
	} func_t;

	localparam logic [1:0] SHEAR_NONE = 2'd0;
	localparam logic [1:0] SHEAR_X    = 2'd1;
	localparam logic [1:0] SHEAR_Y    = 2'd2;
	localparam logic [1:0] SHEAR_XY   = 2'd3;

	localparam logic ST_DONE      = 1'b0;
	localparam logic ST_BAD_SHEAR = 1'b1;

	localparam logic [8:0] DEG_QUARTER = 9'd90;
	localparam logic [8:0] DEG_HALF    = 9'd180;
	localparam logic [8:0] DEG_3Q      = 9'd270;
	localparam logic [8:0] DEG_FULL    = 9'd360;

	// sin(k deg) * 2^16, rounded, k = 0..90
	localparam logic [16:0] QSINE [91] = '{
		17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,
		17'd5712,  17'd6850,  17'd7987,  17'd9121,  17'd10252,
		17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
		17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336,
		17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
		17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
		17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
		17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243,
		17'd42126, 17'd42995, 17'd43852, 17'd44695, 17'd45525,
		17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
		17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
		17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
		17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903,
		17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
		17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997,
		17'd63303, 17'd63589, 17'd63856, 17'd64104, 17'd64332,
		17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
		17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
		17'd65536
	};

	// Signed sine of a whole-degree angle, magnitude rounded half up to frac fraction bits.
	function automatic logic signed [17:0] sine_deg(input logic [8:0] ang, input int frac);
		logic [8:0]  a;
		logic [6:0]  k;
		logic        neg;
		logic [17:0] wide;
		logic [17:0] rnd;
		logic [17:0] mag;
		a = (ang >= DEG_FULL) ? ang - DEG_FULL : ang;
		if (a <= DEG_QUARTER) begin
			k   = a[6:0];
			neg = 1'b0;
		end else if (a <= DEG_HALF) begin
			k   = 7'(DEG_HALF - a);
			neg = 1'b0;
		end else if (a <= DEG_3Q) begin
			k   = 7'(a - DEG_HALF);
			neg = 1'b1;
		end else begin
			k   = 7'(DEG_FULL - a);
			neg = 1'b1;
		end
		wide = {1'b0, QSINE[k]} << 1;
		rnd  = (wide >> (16 - frac)) + 18'd1;
		mag  = rnd >> 1;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

[sv/triangle_affine_transform.sv]
// Top level of the triangle affine transform: input stage, vertex store, result stage.
//
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------------------
//  in      | in_valid/in_ready  | func, load_ax..load_cy, angle_deg, param_x/y, shear_dir
//  out     | out_valid/out_ready| out_ax..out_cy, status
//
// One word per cycle when no stall holds it; a taken word is registered in the input
// stage, then its result in the result stage. A centroid rotation that directly follows
// a word which changed the vertices waits until the registered centroid of the new vertices is formed.
// Reset clears the vertices to zero and empties both stages.
// A stalled output holds the result stage; the input stage still takes a word while
// it is empty or while its word moves on in the same cycle.
module triangle_affine_transform #(
	parameter int COORD_WIDTH    = 16,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [15:0] load_ax,
	input  logic signed [15:0] load_ay,
	input  logic signed [15:0] load_bx,
	input  logic signed [15:0] load_by,
	input  logic signed [15:0] load_cx,
	input  logic signed [15:0] load_cy,
	input  logic [8:0]         angle_deg,
	input  logic signed [15:0] param_x,
	input  logic signed [15:0] param_y,
	input  logic [1:0]         shear_dir,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_ax,
	output logic signed [15:0] out_ay,
	output logic signed [15:0] out_bx,
	output logic signed [15:0] out_by,
	output logic signed [15:0] out_cx,
	output logic signed [15:0] out_cy,
	output logic               status
);

	localparam int CW = COORD_WIDTH;
	localparam int TW = TRIG_FRAC_BITS + 2;
	// divide-by-3 reciprocal: magnitude needs CW+2 bits, one guard bit more
	localparam int RK = CW + 3;
	localparam int PRW = 2 * CW + 5;
	localparam logic [63:0] RECIP3_FULL = (64'd1 << RK) / 64'd3;
	localparam logic [RK-1:0] RECIP3 = RECIP3_FULL[RK-1:0];

	// Sum of three coordinates divided by 3, truncated toward zero.
	function automatic logic signed [CW-1:0] div3_trunc(input logic signed [CW+1:0] s);
		logic            neg;
		logic [CW+1:0]   mag;
		logic [PRW-1:0]  prod;
		logic [CW+1:0]   q0;
		logic [CW+1:0]   rem;
		logic [CW+1:0]   q;
		neg  = s[CW+1];
		mag  = neg ? unsigned'(-s) : unsigned'(s);
		prod = PRW'(mag) * PRW'(RECIP3);
		q0   = prod[PRW-1:RK];
		rem  = mag - (q0 + (q0 << 1));
		q    = (rem >= (CW+2)'(3)) ? q0 + 1'b1 : q0;
		return CW'(neg ? (~q + 1'b1) : q);
	endfunction

	// ---------------- input stage ----------------
	logic                     valid_s1;
	taf_pkg::func_t           func_s1;
	logic signed [15:0]       ld_x_s1 [3];
	logic signed [15:0]       ld_y_s1 [3];
	logic signed [TW-1:0]     sin_s1, cos_s1;
	logic signed [15:0]       px_s1, py_s1;
	logic                     bad_s1;

	// ---------------- vertex store and centroid ----------------
	logic signed [CW-1:0]     vx_q [3];
	logic signed [CW-1:0]     vy_q [3];
	logic signed [CW-1:0]     cen_x_q, cen_y_q;
	logic                     cen_ok_q;

	// ---------------- result stage ----------------
	logic                     out_valid_s2;
	logic signed [15:0]       out_x_s2 [3];
	logic signed [15:0]       out_y_s2 [3];
	logic                     status_s2;

	logic                     in_take;
	logic                     wait_cen;
	logic                     advance;
	logic                     state_we;
	logic [8:0]               ang_red;
	logic [8:0]               ang_cos;
	logic signed [15:0]       px_in, py_in;
	logic                     bad_in;
	logic signed [CW-1:0]     piv_x, piv_y;
	logic signed [CW-1:0]     nx [3];
	logic signed [CW-1:0]     ny [3];

	// hold a centroid rotation until the centroid register matches the vertices
	assign wait_cen = valid_s1 && (func_s1 == taf_pkg::FN_ROT_CENTROID) && !cen_ok_q;
	assign advance  = valid_s1 && !wait_cen && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// fold the angle into one turn and form sine and cosine ahead of the multipliers
	assign ang_red = (angle_deg >= taf_pkg::DEG_FULL) ? angle_deg - taf_pkg::DEG_FULL
		: angle_deg;
	assign ang_cos = ang_red + taf_pkg::DEG_QUARTER;

	// shear direction picks which factor survives; direction none drops the word's effect
	always_comb begin
		px_in  = param_x;
		py_in  = param_y;
		bad_in = 1'b0;
		if (func == taf_pkg::FN_SHEAR) begin
			case (shear_dir)
				taf_pkg::SHEAR_X:    py_in = '0;
				taf_pkg::SHEAR_Y:    px_in = '0;
				taf_pkg::SHEAR_XY:   begin
				end
				taf_pkg::SHEAR_NONE: bad_in = 1'b1;
				default:             bad_in = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1    <= taf_pkg::func_t'(func);
			ld_x_s1[0] <= load_ax;
			ld_y_s1[0] <= load_ay;
			ld_x_s1[1] <= load_bx;
			ld_y_s1[1] <= load_by;
			ld_x_s1[2] <= load_cx;
			ld_y_s1[2] <= load_cy;
			sin_s1     <= TW'(taf_pkg::sine_deg(ang_red, TRIG_FRAC_BITS));
			cos_s1     <= TW'(taf_pkg::sine_deg(ang_cos, TRIG_FRAC_BITS));
			px_s1      <= px_in;
			py_s1      <= py_in;
			bad_s1     <= bad_in;
		end
	end

	// pivot: registered centroid for centroid rotation, origin otherwise
	assign piv_x = (func_s1 == taf_pkg::FN_ROT_CENTROID) ? cen_x_q : '0;
	assign piv_y = (func_s1 == taf_pkg::FN_ROT_CENTROID) ? cen_y_q : '0;

	// one datapath per vertex, all three working on the original coordinates
	for (genvar gi = 0; gi < 3; gi++) begin : g_vtx
		taf_vertex #(
			.COORD_WIDTH    (COORD_WIDTH),
			.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
		) u_vtx (
			.op    (func_s1),
			.x     (vx_q[gi]),
			.y     (vy_q[gi]),
			.pvx   (piv_x),
			.pvy   (piv_y),
			.sin_v (sin_s1),
			.cos_v (cos_s1),
			.px    (px_s1),
			.py    (py_s1),
			.ld_x  (ld_x_s1[gi]),
			.ld_y  (ld_y_s1[gi]),
			.nx    (nx[gi]),
			.ny    (ny[gi])
		);
	end

	// update the store for every real operation; unused codes and bad shears leave it
	always_comb begin
		case (func_s1)
			taf_pkg::FN_LOAD, taf_pkg::FN_ROT_CENTROID, taf_pkg::FN_ROT_ORIGIN,
			taf_pkg::FN_SCALE, taf_pkg::FN_TRANSLATE: state_we = advance;
			taf_pkg::FN_SHEAR: state_we = advance && !bad_s1;
			default: state_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
		end else if (state_we) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= nx[i];
				vy_q[i] <= ny[i];
			end
		end
	end

	// refresh the centroid every cycle; after a write it lags the store until recomputed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_x_q  <= '0;
			cen_y_q  <= '0;
			cen_ok_q <= 1'b1;
		end else begin
			cen_x_q  <= div3_trunc((CW+2)'(vx_q[0]) + (CW+2)'(vx_q[1]) + (CW+2)'(vx_q[2]));
			cen_y_q  <= div3_trunc((CW+2)'(vy_q[0]) + (CW+2)'(vy_q[1]) + (CW+2)'(vy_q[2]));
			cen_ok_q <= !state_we;
		end
	end

	// result stage: drop the word once taken, load a new one when the input stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				out_x_s2[i] <= 16'(state_we ? nx[i] : vx_q[i]);
				out_y_s2[i] <= 16'(state_we ? ny[i] : vy_q[i]);
			end
			status_s2 <= ((func_s1 == taf_pkg::FN_SHEAR) && bad_s1) ? taf_pkg::ST_BAD_SHEAR
				: taf_pkg::ST_DONE;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_ax    = out_x_s2[0];
	assign out_ay    = out_y_s2[0];
	assign out_bx    = out_x_s2[1];
	assign out_by    = out_y_s2[1];
	assign out_cx    = out_x_s2[2];
	assign out_cy    = out_y_s2[2];
	assign status    = status_s2;

endmodule

[sv/taf_vertex.sv]
// Per-vertex datapath: shared multipliers, truncation and saturation for one vertex.
module taf_vertex #(
	parameter int COORD_WIDTH    = 16,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  taf_pkg::func_t                   op,
	input  logic signed [COORD_WIDTH-1:0]    x,
	input  logic signed [COORD_WIDTH-1:0]    y,
	input  logic signed [COORD_WIDTH-1:0]    pvx,
	input  logic signed [COORD_WIDTH-1:0]    pvy,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_v,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_v,
	input  logic signed [15:0]               px,
	input  logic signed [15:0]               py,
	input  logic signed [15:0]               ld_x,
	input  logic signed [15:0]               ld_y,
	output logic signed [COORD_WIDTH-1:0]    nx,
	output logic signed [COORD_WIDTH-1:0]    ny
);

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int BW = (TW > 16) ? TW : 16;
	localparam int AW = COORD_WIDTH + 1;
	localparam int PW = AW + BW;
	localparam int SW = PW + 2;

	localparam logic signed [SW-1:0] RND_ADD =
		{{(SW-TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}};
	localparam logic signed [SW-1:0] SAT_MAX =
		{{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_MIN =
		{{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	logic signed [AW-1:0] dx, dy;
	logic signed [AW-1:0] a0, a1, a2, a3;
	logic signed [BW-1:0] b0, b1, b2, b3;
	logic signed [PW-1:0] m0, m1, m2, m3;
	logic signed [SW-1:0] rx_num, ry_num, rx_adj, ry_adj, rx_q, ry_q;
	logic signed [SW-1:0] cand_x, cand_y;

	assign dx = AW'(x) - AW'(pvx);
	assign dy = AW'(y) - AW'(pvy);

	// operand steering: rotation uses all four, scale and shear reuse m0 and m2
	always_comb begin
		a0 = dx;
		b0 = BW'(cos_v);
		a1 = dy;
		b1 = BW'(sin_v);
		a2 = dx;
		b2 = BW'(sin_v);
		a3 = dy;
		b3 = BW'(cos_v);
		case (op)
			taf_pkg::FN_SCALE: begin
				a0 = AW'(x);
				b0 = BW'(px);
				a2 = AW'(y);
				b2 = BW'(py);
			end
			taf_pkg::FN_SHEAR: begin
				a0 = AW'(y);
				b0 = BW'(px);
				a2 = AW'(x);
				b2 = BW'(py);
			end
			default: begin
			end
		endcase
	end

	assign m0 = a0 * b0;
	assign m1 = a1 * b1;
	assign m2 = a2 * b2;
	assign m3 = a3 * b3;

	// rotation: pivot scaled up, then divide by 2^F truncating toward zero
	assign rx_num = (SW'(pvx) <<< TRIG_FRAC_BITS) + SW'(m0) - SW'(m1);
	assign ry_num = (SW'(pvy) <<< TRIG_FRAC_BITS) + SW'(m2) + SW'(m3);
	assign rx_adj = rx_num + (rx_num[SW-1] ? RND_ADD : '0);
	assign ry_adj = ry_num + (ry_num[SW-1] ? RND_ADD : '0);
	assign rx_q   = rx_adj >>> TRIG_FRAC_BITS;
	assign ry_q   = ry_adj >>> TRIG_FRAC_BITS;

	always_comb begin
		case (op)
			taf_pkg::FN_LOAD: begin
				cand_x = SW'(ld_x);
				cand_y = SW'(ld_y);
			end
			taf_pkg::FN_ROT_CENTROID, taf_pkg::FN_ROT_ORIGIN: begin
				cand_x = rx_q;
				cand_y = ry_q;
			end
			taf_pkg::FN_SCALE: begin
				cand_x = SW'(m0);
				cand_y = SW'(m2);
			end
			taf_pkg::FN_TRANSLATE: begin
				cand_x = SW'(x) + SW'(px);
				cand_y = SW'(y) + SW'(py);
			end
			taf_pkg::FN_SHEAR: begin
				cand_x = SW'(x) + SW'(m0);
				cand_y = SW'(y) + SW'(m2);
			end
			default: begin
				cand_x = SW'(x);
				cand_y = SW'(y);
			end
		endcase
	end

	// clamp to the coordinate range
	always_comb begin
		if (cand_x > SAT_MAX)
			nx = COORD_WIDTH'(SAT_MAX);
		else if (cand_x < SAT_MIN)
			nx = COORD_WIDTH'(SAT_MIN);
		else
			nx = COORD_WIDTH'(cand_x);
		if (cand_y > SAT_MAX)
			ny = COORD_WIDTH'(SAT_MAX);
		else if (cand_y < SAT_MIN)
			ny = COORD_WIDTH'(SAT_MIN);
		else
			ny = COORD_WIDTH'(cand_y);
	end

endmodule
